[rtl/fvmt_pkg.sv]
// Shared types, constants and command/status structs for the feature vector match table.
// Used by every module of the block; depends on nothing.
package fvmt_pkg;

  localparam int unsigned MAX_ENTRIES       = 64;
  localparam int unsigned MAX_VECTOR_LENGTH = 512;
  localparam int unsigned MAX_MATCHES       = 16;

  localparam int unsigned SLOT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned ELEM_W  = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
  localparam int unsigned CAND_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned MATCH_W = $clog2(MAX_MATCHES + 1);
  localparam int unsigned VEC_DEPTH = 2 ** (SLOT_W + ELEM_W);

  localparam int unsigned VLEN_W   = 10;
  localparam int unsigned SIM_W    = 40;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned MAXM_W   = 5;
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [VLEN_W-1:0]       COUNT_MAX    = 10'd1023;
  localparam logic [VLEN_W-1:0]       VLEN_RESET   = 10'd512;
  localparam logic [MAXM_W-1:0]       MAXM_RESET   = 5'd1;
  localparam logic [ID_W-1:0]         ID_MAX       = 16'hFFFF;
  localparam logic signed [SIM_W-1:0] SIM_MAX      = 40'sh7F_FFFF_FFFF;
  localparam logic signed [SIM_W-1:0] SIM_MIN      = 40'sh80_0000_0000;

  typedef enum logic [1:0] {
    MODE_ENROLL      = 2'd0,
    MODE_QUERY       = 2'd1,
    MODE_DELETE_ID   = 2'd2,
    MODE_DELETE_LAST = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NO_MATCH      = 3'd1,
    ST_TABLE_FULL    = 3'd2,
    ST_LEN_MISMATCH  = 3'd3,
    ST_UNKNOWN_ID    = 3'd4,
    ST_EMPTY         = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_LENGTH   = 2'd0,
    CFG_MATCH_THRESHOLD = 2'd1,
    CFG_MAX_MATCHES     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SW_FREE,
    SW_ACC,
    SW_DEL_ID,
    SW_DEL_LAST,
    SW_SELECT
  } sweep_e;

  typedef enum logic [2:0] {
    EM_LEN,
    EM_FULL,
    EM_ENROLL,
    EM_DEL_ID,
    EM_DEL_LAST,
    EM_MATCH,
    EM_NOMATCH
  } emit_e;

  typedef struct packed {
    mode_e                   mode;
    logic signed [VAL_W-1:0] element_value;
    logic                    element_last;
    logic [ID_W-1:0]         target_id;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic [ID_W-1:0]         result_id;
    logic signed [SIM_W-1:0] similarity;
    logic                    result_last;
  } out_item_t;

  typedef struct packed {
    logic   load_item;
    logic   open_stream;
    logic   close_stream;
    logic   count_step;
    logic   write_elem;
    logic   sweep_start;
    sweep_e sweep_kind;
    logic   commit_enroll;
    logic   sel_init;
    logic   kill;
    logic   emit;
    emit_e  emit_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  last;
    logic  new_stream;
    logic  elem_in_range;
    logic  len_bad;
    logic  enroll_blocked;
    logic  sweep_busy;
    logic  found;
    logic  match_last;
    logic  out_free;
  } dp_status_t;

endpackage

[rtl/fvmt_ctrl.sv]
// Sequencing state machine of the feature vector match table.
// Depends on fvmt_pkg; drives fvmt_dpath through ctrl_cmd_t and reads dp_status_t.
module fvmt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  fvmt_pkg::dp_status_t   status_i,
  output fvmt_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_FREE   = 9'b000000100,
    S_ELEM   = 9'b000001000,
    S_ACC    = 9'b000010000,
    S_STEP   = 9'b000100000,
    S_DEL    = 9'b001000000,
    S_SEL    = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  fvmt_pkg::emit_e em_kind_q, em_kind_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    em_kind_d = em_kind_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.mode)
          fvmt_pkg::MODE_ENROLL: begin
            if (status_i.new_stream) begin
              cmd_o.open_stream = 1'b1;
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_kind  = fvmt_pkg::SW_FREE;
              state_d           = S_FREE;
            end else begin
              state_d = S_ELEM;
            end
          end
          fvmt_pkg::MODE_QUERY: begin
            cmd_o.open_stream = status_i.new_stream;
            state_d           = S_ELEM;
          end
          fvmt_pkg::MODE_DELETE_ID: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = fvmt_pkg::SW_DEL_ID;
            em_kind_d         = fvmt_pkg::EM_DEL_ID;
            state_d           = S_DEL;
          end
          default: begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = fvmt_pkg::SW_DEL_LAST;
            em_kind_d         = fvmt_pkg::EM_DEL_LAST;
            state_d           = S_DEL;
          end
        endcase
      end
      S_FREE: begin
        if (!status_i.sweep_busy) state_d = S_ELEM;
      end
      S_ELEM: begin
        if (status_i.mode == fvmt_pkg::MODE_ENROLL) begin
          cmd_o.write_elem = 1'b1;
          state_d          = S_STEP;
        end else if (status_i.elem_in_range) begin
          cmd_o.sweep_start = 1'b1;
          cmd_o.sweep_kind  = fvmt_pkg::SW_ACC;
          state_d           = S_ACC;
        end else begin
          state_d = S_STEP;
        end
      end
      S_ACC: begin
        if (!status_i.sweep_busy) state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.count_step = 1'b1;
        if (status_i.last) begin
          cmd_o.close_stream = 1'b1;
          if (status_i.len_bad) begin
            em_kind_d = fvmt_pkg::EM_LEN;
            state_d   = S_EMIT;
          end else if (status_i.mode == fvmt_pkg::MODE_ENROLL) begin
            if (status_i.enroll_blocked) begin
              em_kind_d = fvmt_pkg::EM_FULL;
            end else begin
              cmd_o.commit_enroll = 1'b1;
              em_kind_d           = fvmt_pkg::EM_ENROLL;
            end
            state_d = S_EMIT;
          end else begin
            cmd_o.sel_init    = 1'b1;
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = fvmt_pkg::SW_SELECT;
            state_d           = S_SEL;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DEL: begin
        if (!status_i.sweep_busy) begin
          cmd_o.kill = 1'b1;
          state_d    = S_EMIT;
        end
      end
      S_SEL: begin
        if (!status_i.sweep_busy) begin
          em_kind_d = status_i.found ? fvmt_pkg::EM_MATCH : fvmt_pkg::EM_NOMATCH;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = em_kind_q;
          if (em_kind_q == fvmt_pkg::EM_MATCH && !status_i.match_last) begin
            cmd_o.sweep_start = 1'b1;
            cmd_o.sweep_kind  = fvmt_pkg::SW_SELECT;
            state_d           = S_SEL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      em_kind_q <= fvmt_pkg::EM_LEN;
    end else begin
      state_q   <= state_d;
      em_kind_q <= em_kind_d;
    end
  end

endmodule

[rtl/fvmt_dpath.sv]
// Datapath of the feature vector match table: vector, id and sum memories, slot sweep
// engine, multiply-accumulate pipeline, ranking registers and output register.
// Depends on fvmt_pkg; commanded by fvmt_ctrl.
module fvmt_dpath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  fvmt_pkg::in_item_t                       in_item_i,
  input  logic                                     cfg_valid_i,
  input  logic [fvmt_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [fvmt_pkg::SIM_W-1:0]               cfg_data_i,
  input  logic                                     out_stall_i,
  output logic                                     out_valid_o,
  output fvmt_pkg::out_item_t                      out_item_o,
  input  fvmt_pkg::ctrl_cmd_t                      cmd_i,
  output fvmt_pkg::dp_status_t                     status_o
);

  localparam int unsigned SW = fvmt_pkg::SLOT_W;
  localparam int unsigned EW = fvmt_pkg::ELEM_W;
  localparam int unsigned ME = fvmt_pkg::MAX_ENTRIES;

  logic [fvmt_pkg::VAL_W-1:0]        vec_mem [fvmt_pkg::VEC_DEPTH];
  logic signed [fvmt_pkg::SIM_W-1:0] sum_mem [ME];
  logic [fvmt_pkg::ID_W-1:0]         id_mem  [ME];

  fvmt_pkg::in_item_t              item_q;
  logic [fvmt_pkg::VLEN_W-1:0]     vlen_q;
  logic signed [fvmt_pkg::SIM_W-1:0] thr_q;
  logic [fvmt_pkg::MAXM_W-1:0]     maxm_q;

  logic                            in_stream_q;
  fvmt_pkg::mode_e                 stream_mode_q;
  logic [fvmt_pkg::VLEN_W-1:0]     elem_cnt_q;
  logic                            pend_ok_q;
  logic [SW-1:0]                   pend_slot_q;
  logic [fvmt_pkg::ID_W-1:0]       next_id_q;
  logic [ME-1:0]                   live_q;
  logic [ME-1:0]                   taken_q;
  logic [fvmt_pkg::MATCH_W-1:0]    n_q;

  logic                            run_q;
  fvmt_pkg::sweep_e                kind_q;
  logic [SW-1:0]                   cnt_q;
  logic                            v1_q;
  logic [SW-1:0]                   s1_q;
  logic                            v2_q;
  logic [SW-1:0]                   s2_q;
  logic                            first_q;

  logic [fvmt_pkg::VAL_W-1:0]        vec_rd_q;
  logic signed [fvmt_pkg::SIM_W-1:0] sum_rd_q;
  logic [fvmt_pkg::ID_W-1:0]         id_rd_q;
  logic signed [fvmt_pkg::PROD_W-1:0] prod_q;
  logic signed [fvmt_pkg::SIM_W-1:0] sumr_q;

  logic                            found_q;
  logic [SW-1:0]                   best_slot_q;
  logic [fvmt_pkg::ID_W-1:0]       best_id_q;
  logic signed [fvmt_pkg::SIM_W-1:0] best_sum_q;
  logic [fvmt_pkg::CAND_W-1:0]     cand_q;

  logic                            out_valid_q;
  fvmt_pkg::out_item_t             out_q;

  logic [EW-1:0]                   elem_idx;
  logic                            elem_in_range;
  logic [fvmt_pkg::VLEN_W:0]       total;
  logic                            len_bad;
  logic                            out_free;
  logic                            live_b;
  logic                            take_free;
  logic                            hit_del;
  logic                            hit_last;
  logic                            sel_qual;
  logic                            sel_better;
  logic [fvmt_pkg::MATCH_W-1:0]    k_lim;
  logic                            match_last;
  logic signed [fvmt_pkg::PROD_W-1:0] prod_d;
  logic signed [fvmt_pkg::SIM_W:0] acc_sum;
  logic signed [fvmt_pkg::SIM_W-1:0] sat_sum;
  logic [fvmt_pkg::ID_W-1:0]       next_id_inc;
  fvmt_pkg::out_item_t             res;

  assign elem_idx      = elem_cnt_q[EW-1:0];
  assign elem_in_range = (elem_cnt_q < vlen_q)
                       && (elem_cnt_q < fvmt_pkg::VLEN_W'(fvmt_pkg::MAX_VECTOR_LENGTH));
  assign total         = {1'b0, elem_cnt_q} + (fvmt_pkg::VLEN_W + 1)'(1);
  assign len_bad       = (vlen_q == '0)
                       || (vlen_q > fvmt_pkg::VLEN_W'(fvmt_pkg::MAX_VECTOR_LENGTH))
                       || (total != {1'b0, vlen_q});
  assign out_free      = !out_valid_q || !out_stall_i;
  assign next_id_inc   = next_id_q + fvmt_pkg::ID_W'(1);

  assign live_b    = live_q[s1_q];
  assign take_free = v1_q && (kind_q == fvmt_pkg::SW_FREE) && !live_b && !pend_ok_q;
  assign hit_del   = v1_q && (kind_q == fvmt_pkg::SW_DEL_ID) && live_b && !found_q
                   && (item_q.target_id != '0) && (id_rd_q == item_q.target_id);
  assign hit_last  = v1_q && (kind_q == fvmt_pkg::SW_DEL_LAST) && live_b
                   && (!found_q || (id_rd_q > best_id_q));
  assign sel_qual  = v1_q && (kind_q == fvmt_pkg::SW_SELECT) && live_b && !taken_q[s1_q]
                   && (sum_rd_q > thr_q);
  assign sel_better = sel_qual && (!found_q || (sum_rd_q > best_sum_q)
                   || ((sum_rd_q == best_sum_q) && (id_rd_q < best_id_q)));

  always_comb begin
    if (maxm_q == '0) begin
      k_lim = fvmt_pkg::MATCH_W'(1);
    end else if (maxm_q > fvmt_pkg::MAXM_W'(fvmt_pkg::MAX_MATCHES)) begin
      k_lim = fvmt_pkg::MATCH_W'(fvmt_pkg::MAX_MATCHES);
    end else begin
      k_lim = fvmt_pkg::MATCH_W'(maxm_q);
    end
  end

  assign match_last = (cand_q == fvmt_pkg::CAND_W'(1))
                    || ((n_q + fvmt_pkg::MATCH_W'(1)) == k_lim);

  assign prod_d  = $signed(item_q.element_value) * $signed(vec_rd_q);
  assign acc_sum = $signed({sumr_q[fvmt_pkg::SIM_W-1], sumr_q})
                 + $signed({{(fvmt_pkg::SIM_W + 1 - fvmt_pkg::PROD_W){prod_q[fvmt_pkg::PROD_W-1]}},
                            prod_q});

  always_comb begin
    if (acc_sum[fvmt_pkg::SIM_W] != acc_sum[fvmt_pkg::SIM_W-1]) begin
      sat_sum = acc_sum[fvmt_pkg::SIM_W] ? fvmt_pkg::SIM_MIN : fvmt_pkg::SIM_MAX;
    end else begin
      sat_sum = acc_sum[fvmt_pkg::SIM_W-1:0];
    end
  end

  always_comb begin
    res             = '0;
    res.result_last = 1'b1;
    case (cmd_i.emit_kind)
      fvmt_pkg::EM_LEN:     res.status = fvmt_pkg::ST_LEN_MISMATCH;
      fvmt_pkg::EM_FULL:    res.status = fvmt_pkg::ST_TABLE_FULL;
      fvmt_pkg::EM_ENROLL: begin
        res.status    = fvmt_pkg::ST_OK;
        res.result_id = next_id_q;
      end
      fvmt_pkg::EM_DEL_ID: begin
        res.status    = found_q ? fvmt_pkg::ST_OK : fvmt_pkg::ST_UNKNOWN_ID;
        res.result_id = item_q.target_id;
      end
      fvmt_pkg::EM_DEL_LAST: begin
        res.status    = found_q ? fvmt_pkg::ST_OK : fvmt_pkg::ST_EMPTY;
        res.result_id = found_q ? best_id_q : '0;
      end
      fvmt_pkg::EM_MATCH: begin
        res.status      = fvmt_pkg::ST_OK;
        res.result_id   = best_id_q;
        res.similarity  = best_sum_q;
        res.result_last = match_last;
      end
      default:              res.status = fvmt_pkg::ST_NO_MATCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q        <= fvmt_pkg::VLEN_RESET;
      thr_q         <= '0;
      maxm_q        <= fvmt_pkg::MAXM_RESET;
      in_stream_q   <= 1'b0;
      stream_mode_q <= fvmt_pkg::MODE_ENROLL;
      elem_cnt_q    <= '0;
      pend_ok_q     <= 1'b0;
      next_id_q     <= '0;
      live_q        <= '0;
      taken_q       <= '0;
      n_q           <= '0;
      run_q         <= 1'b0;
      kind_q        <= fvmt_pkg::SW_FREE;
      cnt_q         <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      first_q       <= 1'b0;
      found_q       <= 1'b0;
      cand_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          fvmt_pkg::CFG_VECTOR_LENGTH:   vlen_q <= cfg_data_i[fvmt_pkg::VLEN_W-1:0];
          fvmt_pkg::CFG_MATCH_THRESHOLD: thr_q  <= $signed(cfg_data_i);
          fvmt_pkg::CFG_MAX_MATCHES:     maxm_q <= cfg_data_i[fvmt_pkg::MAXM_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.open_stream) begin
        in_stream_q   <= 1'b1;
        stream_mode_q <= item_q.mode;
        elem_cnt_q    <= '0;
      end else if (cmd_i.close_stream) begin
        in_stream_q <= 1'b0;
        elem_cnt_q  <= '0;
      end else if (cmd_i.count_step && elem_cnt_q != fvmt_pkg::COUNT_MAX) begin
        elem_cnt_q <= elem_cnt_q + fvmt_pkg::VLEN_W'(1);
      end

      if (cmd_i.sweep_start) begin
        run_q  <= 1'b1;
        kind_q <= cmd_i.sweep_kind;
        cnt_q  <= '0;
        if (cmd_i.sweep_kind == fvmt_pkg::SW_ACC) first_q <= (elem_cnt_q == '0);
      end else if (run_q) begin
        if (cnt_q == SW'(ME - 1)) run_q <= 1'b0;
        else                      cnt_q <= cnt_q + SW'(1);
      end
      v1_q <= run_q;
      v2_q <= v1_q && (kind_q == fvmt_pkg::SW_ACC) && live_b;

      if (cmd_i.sweep_start && cmd_i.sweep_kind == fvmt_pkg::SW_FREE) pend_ok_q <= 1'b0;
      else if (take_free)                                               pend_ok_q <= 1'b1;
      else if (cmd_i.commit_enroll)                                     pend_ok_q <= 1'b0;

      if (cmd_i.sweep_start) begin
        found_q <= 1'b0;
        cand_q  <= '0;
      end else begin
        if (hit_del || hit_last || sel_better) found_q <= 1'b1;
        if (sel_qual) cand_q <= cand_q + fvmt_pkg::CAND_W'(1);
      end

      if (cmd_i.commit_enroll) begin
        live_q[pend_slot_q] <= 1'b1;
        next_id_q           <= next_id_inc;
      end
      if (cmd_i.kill && found_q) live_q[best_slot_q] <= 1'b0;

      if (cmd_i.sel_init) begin
        taken_q <= '0;
        n_q     <= '0;
      end else if (cmd_i.emit && cmd_i.emit_kind == fvmt_pkg::EM_MATCH) begin
        taken_q[best_slot_q] <= 1'b1;
        n_q                  <= n_q + fvmt_pkg::MATCH_W'(1);
      end

      if (cmd_i.emit)    out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    if (take_free)       pend_slot_q <= s1_q;
    if (hit_del || hit_last || sel_better) best_slot_q <= s1_q;
    if (hit_last || sel_better)            best_id_q   <= id_rd_q;
    if (sel_better)                        best_sum_q  <= sum_rd_q;
    s1_q   <= cnt_q;
    s2_q   <= s1_q;
    prod_q <= prod_d;
    sumr_q <= first_q ? '0 : sum_rd_q;
    if (cmd_i.emit) out_q <= res;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_elem && pend_ok_q && elem_in_range) begin
      vec_mem[{pend_slot_q, elem_idx}] <= item_q.element_value;
    end
    vec_rd_q <= vec_mem[{cnt_q, elem_idx}];
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) sum_mem[s2_q] <= sat_sum;
    sum_rd_q <= sum_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_enroll) id_mem[pend_slot_q] <= next_id_inc;
    id_rd_q <= id_mem[cnt_q];
  end

  assign status_o.mode           = item_q.mode;
  assign status_o.last           = item_q.element_last;
  assign status_o.new_stream     = !in_stream_q || (stream_mode_q != item_q.mode);
  assign status_o.elem_in_range  = elem_in_range;
  assign status_o.len_bad        = len_bad;
  assign status_o.enroll_blocked = !pend_ok_q || (next_id_q == fvmt_pkg::ID_MAX);
  assign status_o.sweep_busy     = run_q || v1_q || v2_q;
  assign status_o.found          = found_q;
  assign status_o.match_last     = match_last;
  assign status_o.out_free       = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/feature_vector_match_table.sv]
// Top level of the feature vector match table: controller plus datapath.
// Depends on fvmt_pkg, fvmt_ctrl and fvmt_dpath.
//
// Holds up to 64 enrolled Q1.15 vectors and answers dot-product top-k queries. Items are
// taken one at a time. The first element of an enroll vector adds a search for the lowest
// free slot. A query element within the vector length runs a multiply-accumulate sweep
// over all 64 slots, one slot per cycle, limited by the single read port of the vector
// memory. The last query element adds one ranking sweep and one output per result. A
// delete runs one id sweep. A stalled output register holds the controller in its output
// state until the item ahead is taken. No clearing pass follows reset. A finished result
// waits in an output register while the next item is accepted; configuration writes are
// always ready.
module feature_vector_match_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  fvmt_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output fvmt_pkg::out_item_t            out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fvmt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fvmt_pkg::SIM_W-1:0]     cfg_data_i
);

  fvmt_pkg::ctrl_cmd_t  cmd;
  fvmt_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  fvmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  fvmt_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (dp_status)
  );

endmodule

[rtl/fvmt_checker.sv]
// Port-level checker for the feature vector match table, bound to the top level.
// Depends on fvmt_pkg.
module fvmt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input fvmt_pkg::in_item_t             in_item_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input fvmt_pkg::out_item_t            out_item_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [fvmt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [fvmt_pkg::SIM_W-1:0]     cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while first in work");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != fvmt_pkg::ST_OK |-> out_item_o.result_last)
    else $error("error result not marked last");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == fvmt_pkg::ST_NO_MATCH
      |-> out_item_o.similarity == '0 && out_item_o.result_id == '0)
    else $error("no-match result carries data");

endmodule

bind feature_vector_match_table fvmt_checker u_fvmt_checker (.*);
